[sv/hbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared constants, types and state encoding for the histogram binning engine.
// ----------------------------------------------------------------------------
package hbe_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int MAX_BINS    = 64;

	localparam int SADDR_W = $clog2(MAX_SAMPLES);
	localparam int TOTAL_W = SADDR_W + 1;
	localparam int BADDR_W = $clog2(MAX_BINS);
	localparam int BINS_W  = BADDR_W + 1;
	localparam int CNT_W   = TOTAL_W;
	localparam int DATA_W  = 32;
	localparam int CFG_IDX_W = 2;

	// shared divider: dividend, divisor, quotient, step count
	localparam int DIVA_W  = 48;
	localparam int DIVB_W  = 33;
	localparam int DIVQ_W  = 32;
	localparam int STEP_W  = 6;
	localparam int DIVDV_W = DIVB_W + DIVQ_W;

	// square root unit
	localparam int SQV_W = 44;
	localparam int SQR_W = 22;

	localparam logic [STEP_W-1:0] STEPS_WIDTH = 6'd32;
	localparam logic [STEP_W-1:0] STEPS_NBINS = 6'd7;
	localparam logic [STEP_W-1:0] STEPS_BIN   = 6'd6;
	localparam logic [STEP_W-1:0] STEPS_PROP  = 6'd17;
	localparam logic [STEP_W-1:0] STEPS_BAR   = 6'd8;

	localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAR   = 2'd2;

	localparam logic [7:0] BAR_OFF = 8'd0;
	localparam logic [7:0] BAR_RAW = 8'd1;

	typedef struct packed {
		logic              start;
		logic [DIVA_W-1:0] a;
		logic [DIVB_W-1:0] b;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [DIVQ_W-1:0] q;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [SQV_W-1:0] v;
	} sq_req_t;

	typedef struct packed {
		logic             done;
		logic [SQR_W-1:0] r;
	} sq_rsp_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_CHECK,
		ST_SQRT,
		ST_WDIV,
		ST_NBDIV,
		ST_CLEAR,
		ST_BRD,
		ST_BMUL,
		ST_BSTART,
		ST_BDIV,
		ST_BINC,
		ST_SRD,
		ST_SACC,
		ST_ERD,
		ST_EMUL,
		ST_PDIV,
		ST_RDIV,
		ST_XDIV,
		ST_EMIT,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

[sv/hbe_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/hbe_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_div
// Restoring divider, one quotient bit per cycle, step count set per request.
// ----------------------------------------------------------------------------
module hbe_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hbe_pkg::div_req_t req,
	output hbe_pkg::div_rsp_t      rsp
);
	import hbe_pkg::*;

	logic               run_q;
	logic               done_q;
	logic               ovf_q;
	logic [DIVA_W-1:0]  rem_q;
	logic [DIVDV_W-1:0] dv_q;
	logic [DIVQ_W-1:0]  quo_q;
	logic [STEP_W-1:0]  cnt_q;

	logic [DIVDV_W-1:0] dv_init;
	logic [DIVDV_W-1:0] dv_nxt;
	logic [DIVDV_W-1:0] rem_ext;
	logic               ge;

	assign dv_init = {{DIVQ_W{1'b0}}, req.b} << req.steps;
	assign dv_nxt  = dv_q >> 1;
	assign rem_ext = {{(DIVDV_W - DIVA_W){1'b0}}, rem_q};
	assign ge      = rem_ext >= dv_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= (req.steps != '0);
				done_q <= (req.steps == '0);
			end else if (run_q && cnt_q == STEP_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// quotient overflow: dividend does not fit below divisor << steps
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.a;
			quo_q <= '0;
			dv_q  <= dv_init;
			cnt_q <= req.steps;
			ovf_q <= {{(DIVDV_W - DIVA_W){1'b0}}, req.a} >= dv_init;
		end else if (run_q) begin
			dv_q  <= dv_nxt;
			quo_q <= {quo_q[DIVQ_W-2:0], ge};
			cnt_q <= cnt_q - STEP_W'(1);
			if (ge) begin
				rem_q <= rem_q - dv_nxt[DIVA_W-1:0];
			end
		end
	end

	assign rsp = '{done: done_q, ovf: ovf_q, q: quo_q};

endmodule
`default_nettype wire

[sv/hbe_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_sqrt
// Integer square root, one result bit per cycle (digit-by-digit method).
// ----------------------------------------------------------------------------
module hbe_sqrt (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hbe_pkg::sq_req_t req,
	output hbe_pkg::sq_rsp_t      rsp
);
	import hbe_pkg::*;

	localparam logic [SQV_W-1:0] BIT_TOP = {2'b01, {(SQV_W - 2){1'b0}}};

	logic             run_q;
	logic             done_q;
	logic [SQV_W-1:0] v_q;
	logic [SQV_W-1:0] r_q;
	logic [SQV_W-1:0] bit_q;
	logic [SQV_W-1:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q   <= req.v;
			r_q   <= '0;
			bit_q <= BIT_TOP;
		end else if (run_q) begin
			bit_q <= bit_q >> 2;
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign rsp = '{done: done_q, r: r_q[SQR_W-1:0]};

endmodule
`default_nettype wire

[sv/histogram_binning_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_binning_engine
// Buffers a set of Q16.16 samples, then bins them and streams one item per bin.
//
//   channel  handshake             payload
//   cfg      cfg_we                cfg_index, cfg_data
//   in       in_valid / in_ready   sample, last_sample
//   out      out_valid / out_ready bin_index .. last_bin
//
// Samples load at one item per cycle into the sample RAM.
// The last sample starts the close: an auto width by square root and divider
// when the bin width is 0, the bin count divide, a clear of all 64 count RAM
// entries, then per stored sample a RAM read, multiply, 6-step divide and
// count read-modify-write (no write when the sample is dropped), a scan of
// the counts, and per result item two 17-step and one 8-step divide on the
// shared divider (the bar divide is skipped when bar_scale is 0 or 1).
// in_ready is low from the last sample until the final result is taken.
// ----------------------------------------------------------------------------
module histogram_binning_engine (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hbe_pkg::DATA_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [hbe_pkg::DATA_W-1:0] sample,
	input  wire logic                              last_sample,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [hbe_pkg::BADDR_W-1:0]            bin_index,
	output logic signed [hbe_pkg::DATA_W-1:0]      midpoint,
	output logic [hbe_pkg::CNT_W-1:0]              count,
	output logic [hbe_pkg::CNT_W-1:0]              running_count,
	output logic [16:0]                            proportion,
	output logic [16:0]                            running_proportion,
	output logic [hbe_pkg::CNT_W-1:0]              bar_length,
	output logic                                   no_bins,
	output logic                                   bins_clipped,
	output logic                                   last_bin
);
	import hbe_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic signed [DATA_W-1:0] base_q;
	logic [30:0]              bwidth_q;
	logic [7:0]               bscale_q;

	// set state
	logic [TOTAL_W-1:0]       total_q;
	logic signed [DATA_W-1:0] max_q;
	logic [TOTAL_W-1:0]       n_q;
	logic [DATA_W-1:0]        d_q;
	logic [DATA_W-1:0]        width_q;
	logic [BINS_W-1:0]        bins_q;
	logic                     clip_q;
	logic [BINS_W-1:0]        k_q;
	logic [TOTAL_W-1:0]       j_q;
	logic [BADDR_W-1:0]       bin_q;
	logic [CNT_W-1:0]         sum_q;
	logic [CNT_W-1:0]         maxc_q;
	logic [CNT_W-1:0]         cum_q;
	logic [CNT_W-1:0]         c_q;
	logic [16:0]              prop_q;
	logic [16:0]              rprop_q;
	logic [CNT_W-1:0]         bar_q;
	logic [39:0]              num_s1;
	logic                     neg_s1;
	logic [38:0]              mid_s1;

	// output register
	logic                     ovalid_q;
	logic [BADDR_W-1:0]       oidx_q;
	logic [DATA_W-1:0]        omid_q;
	logic [CNT_W-1:0]         ocnt_q;
	logic [CNT_W-1:0]         orc_q;
	logic [16:0]              oprop_q;
	logic [16:0]              orprop_q;
	logic [CNT_W-1:0]         obar_q;
	logic                     onob_q;
	logic                     oclip_q;
	logic                     olast_q;

	// memories and units
	logic                     st_we;
	logic [SADDR_W-1:0]       st_waddr;
	logic [SADDR_W-1:0]       st_raddr;
	logic [DATA_W-1:0]        st_rdata;
	logic                     cn_we;
	logic [BADDR_W-1:0]       cn_waddr;
	logic [CNT_W-1:0]         cn_wdata;
	logic [BADDR_W-1:0]       cn_raddr;
	logic [CNT_W-1:0]         cn_rdata;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;
	sq_req_t                  sq_req;
	sq_rsp_t                  sq_rsp;

	// helpers
	logic               in_acc;
	logic               out_acc;
	logic               take;
	logic               gt;
	logic [DATA_W-1:0]  d_comb;
	logic [DATA_W-1:0]  wfix;
	logic [SQR_W-1:0]   s_eff;
	logic [32:0]        diff;
	logic [32:0]        mag;
	logic               keep;
	logic [BADDR_W-1:0] bin_sel;
	logic               j_last;
	logic               k_last;
	logic [CNT_W-1:0]   sum_eff;
	logic [CNT_W-1:0]   maxc_eff;
	logic [18:0]        bar_num;

	hbe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (sample),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	hbe_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_counts (
		.clk   (clk),
		.we    (cn_we),
		.waddr (cn_waddr),
		.wdata (cn_wdata),
		.raddr (cn_raddr),
		.rdata (cn_rdata)
	);

	hbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	hbe_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign take    = total_q < TOTAL_W'(MAX_SAMPLES);
	assign gt      = base_q > max_q;
	assign d_comb  = $unsigned(max_q) - $unsigned(base_q);
	assign s_eff   = (sq_rsp.r == '0) ? SQR_W'(1) : sq_rsp.r;
	assign sum_eff  = (sum_q == '0) ? CNT_W'(1) : sum_q;
	assign maxc_eff = (maxc_q == '0) ? CNT_W'(1) : maxc_q;
	assign bar_num  = {11'd0, bscale_q} * {8'd0, c_q};
	assign j_last   = (j_q + TOTAL_W'(1)) == n_q;
	assign k_last   = (k_q + BINS_W'(1)) == bins_q;

	// auto width: fraction dropped above 1.0, zero forced to 1.0
	always_comb begin
		if (div_rsp.q > ONE_Q16) begin
			wfix = {div_rsp.q[DATA_W-1:16], 16'h0000};
		end else if (div_rsp.q == '0) begin
			wfix = ONE_Q16;
		end else begin
			wfix = div_rsp.q;
		end
	end

	assign diff = {st_rdata[DATA_W-1], st_rdata} - {base_q[DATA_W-1], base_q};
	assign mag  = diff[32] ? (~diff + 33'd1) : diff;

	// negative offsets that truncate to zero still land in bin 0
	assign bin_sel = neg_s1 ? '0 : div_rsp.q[BADDR_W-1:0];
	assign keep    = !div_rsp.ovf &&
		(neg_s1 ? (div_rsp.q[BADDR_W-1:0] == '0)
		        : ({1'b0, div_rsp.q[BADDR_W-1:0]} < bins_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && last_sample) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (gt) begin
					state_d = ST_OUT;
				end else if (bwidth_q == '0) begin
					state_d = ST_SQRT;
				end else begin
					state_d = ST_NBDIV;
				end
			end
			ST_SQRT:   if (sq_rsp.done) state_d = ST_WDIV;
			ST_WDIV:   if (div_rsp.done) state_d = ST_NBDIV;
			ST_NBDIV:  if (div_rsp.done) state_d = ST_CLEAR;
			ST_CLEAR: begin
				if (k_q[BADDR_W-1:0] == BADDR_W'(MAX_BINS - 1)) begin
					state_d = ST_BRD;
				end
			end
			ST_BRD:    state_d = ST_BMUL;
			ST_BMUL:   state_d = ST_BSTART;
			ST_BSTART: state_d = ST_BDIV;
			ST_BDIV: begin
				if (div_rsp.done) begin
					if (keep) begin
						state_d = ST_BINC;
					end else begin
						state_d = j_last ? ST_SRD : ST_BRD;
					end
				end
			end
			ST_BINC:   state_d = j_last ? ST_SRD : ST_BRD;
			ST_SRD:    state_d = ST_SACC;
			ST_SACC:   state_d = k_last ? ST_ERD : ST_SRD;
			ST_ERD:    state_d = ST_EMUL;
			ST_EMUL:   state_d = ST_PDIV;
			ST_PDIV:   if (div_rsp.done) state_d = ST_RDIV;
			ST_RDIV: begin
				if (div_rsp.done) begin
					state_d = (bscale_q > BAR_RAW) ? ST_XDIV : ST_EMIT;
				end
			end
			ST_XDIV:   if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT:   state_d = ST_OUT;
			ST_OUT: begin
				if (out_acc) begin
					state_d = olast_q ? ST_LOAD : ST_ERD;
				end
			end
			default:   state_d = ST_LOAD;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		st_we     = 1'b0;
		st_waddr  = total_q[SADDR_W-1:0];
		st_raddr  = j_q[SADDR_W-1:0];
		cn_we     = 1'b0;
		cn_waddr  = k_q[BADDR_W-1:0];
		cn_wdata  = '0;
		cn_raddr  = k_q[BADDR_W-1:0];
		div_req   = '0;
		sq_req    = '0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				st_we    = in_acc && take;
			end
			ST_CHECK: begin
				if (!gt && bwidth_q == '0) begin
					sq_req.start = 1'b1;
					sq_req.v     = {n_q, 33'd0};
				end else if (!gt) begin
					div_req.start = 1'b1;
					div_req.a     = DIVA_W'(d_comb);
					div_req.b     = DIVB_W'(bwidth_q);
					div_req.steps = STEPS_NBINS;
				end
			end
			ST_SQRT: begin
				if (sq_rsp.done) begin
					div_req.start = 1'b1;
					div_req.a     = {d_q, 16'h0000};
					div_req.b     = DIVB_W'(s_eff);
					div_req.steps = STEPS_WIDTH;
				end
			end
			ST_WDIV: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.a     = DIVA_W'(d_q);
					div_req.b     = DIVB_W'(wfix);
					div_req.steps = STEPS_NBINS;
				end
			end
			ST_CLEAR: begin
				cn_we = 1'b1;
			end
			ST_BSTART: begin
				div_req.start = 1'b1;
				div_req.a     = DIVA_W'(num_s1);
				div_req.b     = DIVB_W'(d_q) + DIVB_W'(1);
				div_req.steps = STEPS_BIN;
			end
			ST_BDIV: begin
				cn_raddr = bin_sel;
			end
			ST_BINC: begin
				cn_we    = 1'b1;
				cn_waddr = bin_q;
				cn_wdata = cn_rdata + CNT_W'(1);
			end
			ST_EMUL: begin
				div_req.start = 1'b1;
				div_req.a     = DIVA_W'({cn_rdata, 16'h0000});
				div_req.b     = DIVB_W'(sum_eff);
				div_req.steps = STEPS_PROP;
			end
			ST_PDIV: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.a     = DIVA_W'({cum_q, 16'h0000});
					div_req.b     = DIVB_W'(sum_eff);
					div_req.steps = STEPS_PROP;
				end
			end
			ST_RDIV: begin
				if (div_rsp.done && bscale_q > BAR_RAW) begin
					div_req.start = 1'b1;
					div_req.a     = DIVA_W'(bar_num);
					div_req.b     = DIVB_W'(maxc_eff);
					div_req.steps = STEPS_BAR;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			bwidth_q <= '0;
			bscale_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:  base_q   <= cfg_data;
				REG_WIDTH: bwidth_q <= cfg_data[30:0];
				REG_BAR:   bscale_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			total_q  <= '0;
			max_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && take) begin
				total_q <= total_q + TOTAL_W'(1);
				if (total_q == '0 || sample > max_q) begin
					max_q <= sample;
				end
			end
			if (state_d == ST_OUT && state_q != ST_OUT) begin
				ovalid_q <= 1'b1;
			end else if (out_acc) begin
				ovalid_q <= 1'b0;
				if (olast_q) begin
					total_q <= '0;
					max_q   <= '0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && last_sample) begin
					n_q <= take ? (total_q + TOTAL_W'(1)) : total_q;
				end
			end
			ST_CHECK: begin
				d_q     <= d_comb;
				width_q <= DATA_W'(bwidth_q);
				if (gt) begin
					oidx_q   <= '0;
					omid_q   <= '0;
					ocnt_q   <= '0;
					orc_q    <= '0;
					oprop_q  <= '0;
					orprop_q <= '0;
					obar_q   <= '0;
					onob_q   <= 1'b1;
					oclip_q  <= 1'b0;
					olast_q  <= 1'b1;
				end
			end
			ST_WDIV: begin
				if (div_rsp.done) begin
					width_q <= wfix;
				end
			end
			ST_NBDIV: begin
				if (div_rsp.done) begin
					if (div_rsp.ovf || div_rsp.q[BINS_W-1:0] > BINS_W'(MAX_BINS)) begin
						bins_q <= BINS_W'(MAX_BINS);
						clip_q <= 1'b1;
					end else begin
						bins_q <= (div_rsp.q[BINS_W-1:0] == '0) ? BINS_W'(1)
						                                        : div_rsp.q[BINS_W-1:0];
						clip_q <= 1'b0;
					end
					k_q <= '0;
				end
			end
			ST_CLEAR: begin
				k_q <= k_q + BINS_W'(1);
				j_q <= '0;
			end
			ST_BMUL: begin
				num_s1 <= {33'd0, bins_q} * {7'd0, mag};
				neg_s1 <= diff[32];
			end
			ST_BDIV: begin
				if (div_rsp.done) begin
					bin_q <= bin_sel;
					if (!keep) begin
						j_q <= j_q + TOTAL_W'(1);
					end
					k_q    <= '0;
					sum_q  <= '0;
					maxc_q <= '0;
				end
			end
			ST_BINC: begin
				j_q <= j_q + TOTAL_W'(1);
			end
			ST_SACC: begin
				sum_q <= sum_q + cn_rdata;
				if (cn_rdata > maxc_q) begin
					maxc_q <= cn_rdata;
				end
				k_q   <= k_last ? '0 : (k_q + BINS_W'(1));
				cum_q <= '0;
			end
			ST_EMUL: begin
				c_q    <= cn_rdata;
				cum_q  <= cum_q + cn_rdata;
				mid_s1 <= {32'd0, k_q[BADDR_W-1:0], 1'b1} * {7'd0, width_q};
			end
			ST_PDIV: begin
				if (div_rsp.done) begin
					prop_q <= div_rsp.q[16:0];
				end
			end
			ST_RDIV: begin
				if (div_rsp.done) begin
					rprop_q <= div_rsp.q[16:0];
					bar_q   <= (bscale_q == BAR_OFF) ? '0 : c_q;
				end
			end
			ST_XDIV: begin
				if (div_rsp.done) begin
					bar_q <= CNT_W'(div_rsp.q[7:0]);
				end
			end
			ST_EMIT: begin
				oidx_q   <= k_q[BADDR_W-1:0];
				omid_q   <= $unsigned(base_q) + mid_s1[32:1];
				ocnt_q   <= c_q;
				orc_q    <= cum_q;
				oprop_q  <= prop_q;
				orprop_q <= rprop_q;
				obar_q   <= bar_q;
				onob_q   <= 1'b0;
				oclip_q  <= clip_q;
				olast_q  <= k_last;
			end
			ST_OUT: begin
				if (out_acc) begin
					k_q <= k_q + BINS_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid          = ovalid_q;
	assign bin_index          = oidx_q;
	assign midpoint           = omid_q;
	assign count              = ocnt_q;
	assign running_count      = orc_q;
	assign proportion         = oprop_q;
	assign running_proportion = orprop_q;
	assign bar_length         = obar_q;
	assign no_bins            = onob_q;
	assign bins_clipped       = oclip_q;
	assign last_bin           = olast_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_W'(MAX_SAMPLES))
		else $error("sample total past store depth");

	a_nobins_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_bins) |-> last_bin)
		else $error("empty result not marked last");

	a_cnt_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BINC) |-> (cn_rdata != '1))
		else $error("bin count wrapped");

	a_out_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_EMIT || $past(state_q) == ST_CHECK))
		else $error("result shown without being built");

endmodule
`default_nettype wire
